### hdl/kvps_pkg.sv
`timescale 1ns / 1ps
package kvps_pkg;
  localparam int unsigned KeyW     = 64;
  localparam int unsigned PayW     = 64;
  localparam int unsigned PairW    = KeyW + PayW;
  localparam int unsigned Capacity = 64;

  typedef logic [KeyW-1:0]  key_t;
  typedef logic [PayW-1:0]  pay_t;
  typedef logic [PairW-1:0] pair_t;

  typedef struct packed {
    logic rd_en;
    logic wr_en;
  } mem_ctrl_t;

  // signed order on raw bit patterns
  function automatic logic key_greater(key_t a, key_t b);
    return $signed(a) > $signed(b);
  endfunction
endpackage

### hdl/kvps_mem.sv
`timescale 1ns / 1ps
module kvps_mem import kvps_pkg::*; #(
  parameter int unsigned CAPACITY = Capacity,
  parameter int unsigned AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1
) (
  input  logic      clk_i,
  input  mem_ctrl_t ctrl_i,
  input  logic [AW-1:0] rd_addr_i,
  input  logic [AW-1:0] wr_addr_i,
  input  pair_t     wr_data_i,
  output pair_t     rd_data_o
);
  pair_t mem_q [CAPACITY];
  pair_t rd_data_q;

  always_ff @(posedge clk_i) begin
    if (ctrl_i.wr_en) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (ctrl_i.rd_en) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;
endmodule

### hdl/key_value_pair_sorter.sv
`timescale 1ns / 1ps
// Channel  Dir  tdata                          tlast        tuser
// s_axis   in   sort_key[63:0] payload[127:64] final_pair   -
// m_axis   out  sorted_key[63:0] sorted_payload[127:64] end_of_run overflowed
// Insertion: each stored key greater than the new one moves up one place,
// with one read and one write per shifted entry; then the new pair is written.
// Output: each result is read, then held until taken.
// Reset empties the set; memory contents need none.
// A stalled output holds the read register; no input is taken meanwhile.
module key_value_pair_sorter import kvps_pkg::*; #(
  parameter int unsigned CAPACITY = Capacity
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              s_axis_tvalid,
  output logic              s_axis_tready,
  input  logic [PairW-1:0]  s_axis_tdata,   // sort_key, payload
  input  logic              s_axis_tlast,   // final_pair
  output logic              m_axis_tvalid,
  input  logic              m_axis_tready,
  output logic [PairW-1:0]  m_axis_tdata,   // sorted_key, sorted_payload
  output logic              m_axis_tlast,   // end_of_run
  output logic              m_axis_tuser    // overflowed
);
  localparam int unsigned AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned CW = $clog2(CAPACITY + 1);
  localparam logic [CW-1:0] CapC = CW'(CAPACITY);
  localparam logic [CW-1:0] OneC = CW'(1);

  localparam logic [2:0] StIdle  = 3'd0;
  localparam logic [2:0] StShRd  = 3'd1;
  localparam logic [2:0] StShCmp = 3'd2;
  localparam logic [2:0] StOutRd = 3'd3;
  localparam logic [2:0] StOutWt = 3'd4;

  logic [2:0]    state_q, state_d;
  logic [CW-1:0] fill_q, fill_d, pos_q, pos_d, idx_q, idx_d;
  logic          ovf_q, ovf_d, fin_q, fin_d;
  pair_t         new_q, new_d;
  mem_ctrl_t     ctrl;
  logic [AW-1:0] rd_addr, wr_addr;
  pair_t         wr_data, rd_data;
  logic [CW-1:0] pos_m1;

  assign pos_m1 = pos_q - OneC;

  kvps_mem #(.CAPACITY(CAPACITY), .AW(AW)) u_mem (
    .clk_i    (clk_i),
    .ctrl_i   (ctrl),
    .rd_addr_i(rd_addr),
    .wr_addr_i(wr_addr),
    .wr_data_i(wr_data),
    .rd_data_o(rd_data)
  );

  assign s_axis_tready = (state_q == StIdle);
  assign m_axis_tvalid = (state_q == StOutWt);
  assign m_axis_tdata  = rd_data;
  assign m_axis_tlast  = (idx_q + OneC == fill_q);
  assign m_axis_tuser  = ovf_q;

  always_comb begin
    state_d = state_q;
    fill_d  = fill_q;
    pos_d   = pos_q;
    idx_d   = idx_q;
    ovf_d   = ovf_q;
    fin_d   = fin_q;
    new_d   = new_q;
    ctrl    = '0;
    rd_addr = pos_m1[AW-1:0];
    wr_addr = pos_q[AW-1:0];
    wr_data = new_q;
    unique case (state_q)
      StIdle: begin
        if (s_axis_tvalid) begin
          new_d = s_axis_tdata;
          fin_d = s_axis_tlast;
          pos_d = fill_q;
          if (fill_q == CapC) begin
            ovf_d = 1'b1;
            if (s_axis_tlast) begin
              idx_d   = '0;
              state_d = StOutRd;
            end
          end else begin
            state_d = StShRd;
          end
        end
      end
      StShRd: begin
        if (pos_q == '0) begin
          ctrl.wr_en = 1'b1;
          fill_d     = fill_q + OneC;
          idx_d      = '0;
          state_d    = fin_q ? StOutRd : StIdle;
        end else begin
          ctrl.rd_en = 1'b1;
          state_d    = StShCmp;
        end
      end
      StShCmp: begin
        ctrl.wr_en = 1'b1;
        if (key_greater(rd_data[KeyW-1:0], new_q[KeyW-1:0])) begin
          // move the larger pair up one place
          wr_data = rd_data;
          pos_d   = pos_m1;
          state_d = StShRd;
        end else begin
          fill_d  = fill_q + OneC;
          idx_d   = '0;
          state_d = fin_q ? StOutRd : StIdle;
        end
      end
      StOutRd: begin
        ctrl.rd_en = 1'b1;
        rd_addr    = idx_q[AW-1:0];
        state_d    = StOutWt;
      end
      StOutWt: begin
        if (m_axis_tready) begin
          if (m_axis_tlast) begin
            fill_d  = '0;
            ovf_d   = 1'b0;
            state_d = StIdle;
          end else begin
            idx_d   = idx_q + OneC;
            state_d = StOutRd;
          end
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      fill_q  <= '0;
      ovf_q   <= 1'b0;
      pos_q   <= '0;
      idx_q   <= '0;
      fin_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      fill_q  <= fill_d;
      ovf_q   <= ovf_d;
      pos_q   <= pos_d;
      idx_q   <= idx_d;
      fin_q   <= fin_d;
    end
  end

  always_ff @(posedge clk_i) begin
    new_q <= new_d;
  end

  a_fill_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= CapC) else $error("fill beyond capacity");
  a_out_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (fill_q != '0) && (idx_q < fill_q)) else $error("empty output");
  a_last_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tready && m_axis_tlast |=> fill_q == '0 && !ovf_q)
    else $error("set not cleared");
  a_pos_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StShRd) |-> pos_q <= fill_q) else $error("insert position");
endmodule
